### src/kcl_pkg.sv
// kcl_pkg: shared types, constants and the key matrix scan for the keypad code lock
// used by kcl_in_stage, kcl_core and keypad_code_lock_arming; depends on nothing
package kcl_pkg;

  // key matrix geometry and special key codes
  localparam int unsigned MATRIX_COLS = 3;
  localparam int unsigned MATRIX_ROWS = 4;
  localparam int unsigned KEY_W       = 4;
  localparam int unsigned KEYS_W      = MATRIX_COLS * MATRIX_ROWS;
  localparam int unsigned ZONES_W     = 4;
  localparam logic [KEY_W-1:0] NO_KEY    = 4'd15;
  localparam logic [KEY_W-1:0] ENTER_KEY = 4'd11;

  // configuration register
  localparam int unsigned CODE_W     = 14;
  localparam logic [CODE_W-1:0] CODE_RESET = 14'd487;

  // default entry length
  localparam int unsigned CODE_DIGITS_DEF = 4;

  // result fields
  localparam int unsigned BEEP_W  = 2;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [BEEP_W-1:0] {
    BEEP_NONE   = 2'd0,
    BEEP_ACCEPT = 2'd1,
    BEEP_REJECT = 2'd2
  } beep_t;

  // one registered poll: scanned key and zone contacts
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [ZONES_W-1:0] zones;
  } poll_t;

  // one result item
  typedef struct packed {
    logic [COUNT_W-1:0] digits_entered;
    beep_t              beep;
    logic               alarm;
    logic [ZONES_W-1:0] zone_leds;
    logic               relay_on;
  } result_t;

  // bits for the largest decimal-weighted entry value, every digit up to ten
  function automatic int unsigned entry_width(input int unsigned digits);
    longint unsigned maxv;
    int unsigned w;
    maxv = 0;
    for (int unsigned i = 0; i < digits; i++) begin
      maxv = maxv * 10 + 10;
    end
    w = 1;
    while ((longint'(1) << w) <= maxv) begin
      w++;
    end
    return w;
  endfunction

  // first closed key, columns first then rows; no key when nothing is closed
  function automatic logic [KEY_W-1:0] scan_matrix(input logic [KEYS_W-1:0] keys);
    logic [KEY_W-1:0] hit;
    hit = NO_KEY;
    // walk backward so the earliest key in scan order is assigned last
    for (int c = MATRIX_COLS - 1; c >= 0; c--) begin
      for (int r = MATRIX_ROWS - 1; r >= 0; r--) begin
        if (keys[r * MATRIX_COLS + c]) begin
          hit = KEY_W'(r * MATRIX_COLS + c);
        end
      end
    end
    return hit;
  endfunction

endpackage

### src/kcl_in_stage.sv
// kcl_in_stage: input register of the code lock; scans the key matrix on entry
// depends on kcl_pkg
module kcl_in_stage
  import kcl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KEYS_W-1:0]  keys_down,
  input  logic [ZONES_W-1:0] zone_open,
  output logic               poll_valid,
  input  logic               poll_take,
  output poll_t              poll
);

  logic  valid_r, valid_nxt;
  poll_t poll_r;

  // stage is free when empty or being drained this cycle
  assign in_ready   = !valid_r || poll_take;
  assign poll_valid = valid_r;
  assign poll       = poll_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload register, scanned key and zone contacts
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      poll_r.key   <= scan_matrix(keys_down);
      poll_r.zones <= zone_open;
    end
  end

endmodule

### src/kcl_core.sv
// kcl_core: entry state, code compare, arming and the result register
// depends on kcl_pkg
module kcl_core
  import kcl_pkg::*;
#(
  parameter int unsigned CODE_DIGITS = CODE_DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CODE_W-1:0] security_code,
  input  logic              poll_valid,
  output logic              poll_take,
  input  poll_t             poll,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  localparam int unsigned CNT_W = $clog2(CODE_DIGITS + 1);
  localparam int unsigned VAL_W = entry_width(CODE_DIGITS);
  localparam int unsigned CMP_W = (VAL_W > CODE_W) ? VAL_W : CODE_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CODE_DIGITS);

  logic             armed_r, armed_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [KEY_W-1:0] last_r, last_nxt;
  logic [VAL_W-1:0] acc_r, acc_nxt;
  logic             valid_r, valid_nxt;
  result_t          res_r;
  beep_t            beep;
  logic             advance;
  logic             match;

  // result register frees when empty or taken
  assign advance   = !valid_r || res_ready;
  assign poll_take = advance;
  assign res_valid = valid_r;
  assign res       = res_r;
  assign match     = (CMP_W'(acc_r) == CMP_W'(security_code));

  // entry and arming update for one poll
  always_comb begin
    armed_nxt = armed_r;
    count_nxt = count_r;
    last_nxt  = last_r;
    acc_nxt   = acc_r;
    beep      = BEEP_NONE;
    if (count_r != FULL_CNT) begin
      if (poll.key != last_r) begin
        if (poll.key == NO_KEY || poll.key == ENTER_KEY) begin
          last_nxt = NO_KEY;
        end else begin
          last_nxt  = poll.key;
          count_nxt = count_r + CNT_W'(1);
          acc_nxt   = (acc_r * VAL_W'(10)) + VAL_W'(poll.key);
        end
      end
    end else if (poll.key == ENTER_KEY) begin
      if (match) begin
        armed_nxt = !armed_r;
        beep      = BEEP_ACCEPT;
      end else begin
        beep = BEEP_REJECT;
      end
      count_nxt = '0;
      acc_nxt   = '0;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = poll_valid;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      count_r <= '0;
      last_r  <= NO_KEY;
      acc_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (advance && poll_valid) begin
        armed_r <= armed_nxt;
        count_r <= count_nxt;
        last_r  <= last_nxt;
        acc_r   <= acc_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (advance && poll_valid) begin
      res_r.relay_on       <= armed_nxt;
      res_r.zone_leds      <= armed_nxt ? ~poll.zones : '0;
      res_r.alarm          <= armed_nxt && (poll.zones != '0);
      res_r.beep           <= beep;
      res_r.digits_entered <= COUNT_W'(count_nxt);
    end
  end

endmodule

### src/keypad_code_lock_arming.sv
// Keypad code lock with arming relay: one poll of the 3x4 key matrix and four zone
// contacts per input transaction, one result transaction per poll. A poll passes an
// input register (where the matrix is scanned) and a result register, so the block
// takes one poll per clock cycle when the result side keeps up; a result becomes valid
// once its poll has passed the input register and then the result register. While
// the result side stalls, the two registers hold two polls and then the input stalls.
// The code is the decimal-weighted sum of the entered key indices, built up digit
// by digit as keys arrive, so enter needs only one compare. The security code may be
// written only while no poll is in flight.
//
// depends on kcl_pkg, kcl_in_stage, kcl_core
module keypad_code_lock_arming
  import kcl_pkg::*;
#(
  parameter int unsigned CODE_DIGITS = CODE_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // security_code
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CODE_W-1:0]     cfg_data,
  // keys_down [11:0], zone_open [15:12]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // relay_on [0], zone_leds [4:1], alarm [5], beep [7:6], digits_entered [10:8]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic [CODE_W-1:0] code_r;
  logic              poll_valid;
  logic              poll_take;
  poll_t             poll;
  result_t           res;

  // configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= CODE_RESET;
    end else if (cfg_valid) begin
      code_r <= cfg_data;
    end
  end

  kcl_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .keys_down  (in_tdata[KEYS_W-1:0]),
    .zone_open  (in_tdata[KEYS_W +: ZONES_W]),
    .poll_valid (poll_valid),
    .poll_take  (poll_take),
    .poll       (poll)
  );

  kcl_core #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .security_code (code_r),
    .poll_valid    (poll_valid),
    .poll_take     (poll_take),
    .poll          (poll),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .res           (res)
  );

  // pack result fields, zero fill to whole bytes
  assign out_tdata = OUT_DATA_W'(res);

endmodule

### src/kcl_checker.sv
// kcl_checker: port-level assertions for keypad_code_lock_arming
// bound to the top level at the end of this file; depends on nothing
module kcl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // stalled result transaction holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // disarmed shows no leds and no alarm
  a_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[5:1] == 5'd0)
    else $error("leds or alarm while disarmed");

  // a beep comes only with a cleared entry
  a_beep_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7:6] != 2'd0 |-> out_tdata[10:8] == 3'd0 &&
      out_tdata[7:6] != 2'd3)
    else $error("beep without cleared entry");

  // an empty block takes an input transaction
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tvalid && !out_tvalid |=> in_tready)
    else $error("idle block not ready");

endmodule

bind keypad_code_lock_arming kcl_checker u_kcl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
